@@ rtl/i2cee_pkg.sv @@
// Shared types and constants for the I2C serial-memory master.
// No dependencies; every other file in rtl/ refers to it by scoped names.
package i2cee_pkg;

  localparam int PAGE_BYTES  = 32;
  localparam int ADDR_BITS   = 13;
  localparam int PAGE_IDX_W  = $clog2(PAGE_BYTES);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 8;

  localparam logic [6:0] DEVICE_ADDRESS_RESET = 7'd80;
  localparam logic [7:0] ACK_TIMEOUT_RESET    = 8'd250;

  typedef logic [PAGE_IDX_W-1:0] page_idx_t;
  typedef logic [ADDR_BITS-1:0]  addr_t;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_LOAD  = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEVICE_ADDRESS = 1'b0,
    CFG_ACK_TIMEOUT    = 1'b1
  } cfg_idx_t;

  typedef enum logic [4:0] {
    PH_IDLE      = 5'd0,
    PH_ST_A      = 5'd1,
    PH_ST_B      = 5'd2,
    PH_ST_C      = 5'd3,
    PH_W_LOW     = 5'd4,
    PH_W_DATA    = 5'd5,
    PH_W_HIGH    = 5'd6,
    PH_W_END_LOW = 5'd7,
    PH_W_END_REL = 5'd8,
    PH_ACK_HIGH  = 5'd9,
    PH_ACK_WAIT  = 5'd10,
    PH_R_LOW     = 5'd11,
    PH_R_REL     = 5'd12,
    PH_R_HIGH    = 5'd13,
    PH_R_SAMPLE  = 5'd14,
    PH_MA_LOW    = 5'd15,
    PH_MA_SDA    = 5'd16,
    PH_MA_HIGH   = 5'd17,
    PH_MA_END    = 5'd18,
    PH_SP_A      = 5'd19,
    PH_SP_B      = 5'd20,
    PH_SP_C      = 5'd21
  } phase_t;

  // Configuration write as seen by the sequencer
  typedef struct packed {
    logic                  we;
    cfg_idx_t              index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  // Classified input beat held in the queue
  typedef struct packed {
    opcode_t   kind;
    logic      load_ok;
    addr_t     addr;
    page_idx_t bidx;
    logic [7:0] wbyte;
    logic [7:0] rlen;
    logic      sda;
  } item_t;

  // One result beat
  typedef struct packed {
    logic       scl;
    logic       sda;
    logic [7:0] read_data;
    logic       read_valid;
    logic       read_last;
    logic       busy;
    logic       ack_timed_out;
  } result_t;

endpackage

@@ rtl/i2cee_front.sv @@
// Front end: accepts input beats, classifies them and queues them for the sequencer.
// Depends on i2cee_pkg.
module i2cee_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          opcode,
  input  logic [12:0]         mem_address,
  input  logic [4:0]          buffer_index,
  input  logic [7:0]          write_byte,
  input  logic [7:0]          read_length,
  input  logic                sda_in,
  output logic                q_valid,
  output i2cee_pkg::item_t    q_item,
  input  logic                q_pop
);

  i2cee_pkg::item_t                 queue_mem [i2cee_pkg::QUEUE_DEPTH];
  logic [i2cee_pkg::QPTR_W-1:0]     wr_ptr;
  logic [i2cee_pkg::QPTR_W-1:0]     rd_ptr;
  logic [i2cee_pkg::QPTR_W:0]       count;
  logic [i2cee_pkg::QPTR_W:0]       count_next;
  logic                             push;
  i2cee_pkg::item_t                 item_in;

  // Classify the incoming beat
  always_comb begin
    item_in.kind    = i2cee_pkg::opcode_t'(opcode);
    item_in.load_ok = (int'(buffer_index) < i2cee_pkg::PAGE_BYTES);
    item_in.addr    = i2cee_pkg::addr_t'(mem_address);
    item_in.bidx    = i2cee_pkg::page_idx_t'(buffer_index);
    item_in.wbyte   = write_byte;
    item_in.rlen    = read_length;
    item_in.sda     = sda_in;
  end

  assign in_ready = (count != (i2cee_pkg::QPTR_W + 1)'(i2cee_pkg::QUEUE_DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != '0);
  assign q_item   = queue_mem[rd_ptr];

  // Track queue fill
  always_comb begin
    count_next = count;
    if (push && !q_pop) begin
      count_next = count + 1'b1;
    end else if (!push && q_pop) begin
      count_next = count - 1'b1;
    end
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  // Store queued beats
  always_ff @(posedge clk) begin
    if (push) begin
      queue_mem[wr_ptr] <= item_in;
    end
  end

endmodule

@@ rtl/i2cee_back.sv @@
// Back end: bus phase sequencer, page buffer, configuration registers, result register.
// Depends on i2cee_pkg.
module i2cee_back (
  input  logic                 clk,
  input  logic                 rst,
  input  i2cee_pkg::cfg_wr_t   cfg,
  input  logic                 q_valid,
  input  i2cee_pkg::item_t     q_item,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output i2cee_pkg::result_t   res
);

  localparam logic [7:0] WRITE_BYTES = 8'(3 + i2cee_pkg::PAGE_BYTES);

  logic [7:0]          page_buffer [i2cee_pkg::PAGE_BYTES];
  i2cee_pkg::phase_t   phase, phase_next;
  logic [3:0]          bit_count, bit_count_next;
  logic [7:0]          byte_count, byte_count_next;
  logic [7:0]          shift_reg, shift_reg_next;
  logic [7:0]          ack_wait_count, ack_wait_count_next;
  i2cee_pkg::addr_t    target_address;
  logic [7:0]          bytes_wanted;
  logic                mode_is_read;
  logic                scl_reg, scl_reg_next;
  logic                sda_reg, sda_reg_next;
  logic [6:0]          device_address;
  logic [7:0]          ack_timeout;
  i2cee_pkg::result_t  res_next;

  logic       tick, is_idle, start_cmd, load_cmd;
  logic [7:0] wait_inc, byte_inc, tx_sel, tx_off, tx_byte, dev;
  logic [3:0] bit_inc;
  logic       ack_done, tout;
  logic [7:0] rdata;
  logic       rvalid, rlast;

  assign q_pop     = q_valid && (!out_valid || out_ready);
  assign tick      = (q_item.kind == i2cee_pkg::OP_TICK);
  assign is_idle   = (phase == i2cee_pkg::PH_IDLE);
  assign start_cmd = !tick && is_idle &&
                     (q_item.kind == i2cee_pkg::OP_WRITE || q_item.kind == i2cee_pkg::OP_READ);
  assign load_cmd  = is_idle && (q_item.kind == i2cee_pkg::OP_LOAD) && q_item.load_ok;
  assign wait_inc  = ack_wait_count + 8'd1;
  assign byte_inc  = byte_count + 8'd1;
  assign bit_inc   = bit_count + 4'd1;
  assign ack_done  = !q_item.sda || (wait_inc >= ack_timeout);
  assign dev       = {device_address, 1'b0};

  // Pick the outgoing byte: after a start condition the current slot, after an ack the next
  assign tx_sel = (phase == i2cee_pkg::PH_ST_C) ? byte_count : byte_inc;
  assign tx_off = tx_sel - 8'd3;
  always_comb begin
    if (tx_sel == 8'd0) begin
      tx_byte = dev;
    end else if (tx_sel == 8'd1) begin
      tx_byte = 8'(target_address >> 8);
    end else if (tx_sel == 8'd2) begin
      tx_byte = target_address[7:0];
    end else if (mode_is_read) begin
      tx_byte = dev | 8'd1;
    end else begin
      tx_byte = page_buffer[tx_off[i2cee_pkg::PAGE_IDX_W-1:0]];
    end
  end

  // Next phase
  always_comb begin
    phase_next = phase;
    if (!tick) begin
      if (start_cmd) begin
        phase_next = i2cee_pkg::PH_ST_A;
      end
    end else begin
      unique case (phase)
        i2cee_pkg::PH_IDLE:      phase_next = i2cee_pkg::PH_IDLE;
        i2cee_pkg::PH_ST_A:      phase_next = i2cee_pkg::PH_ST_B;
        i2cee_pkg::PH_ST_B:      phase_next = i2cee_pkg::PH_ST_C;
        i2cee_pkg::PH_ST_C:      phase_next = i2cee_pkg::PH_W_LOW;
        i2cee_pkg::PH_W_LOW:     phase_next = i2cee_pkg::PH_W_DATA;
        i2cee_pkg::PH_W_DATA:    phase_next = i2cee_pkg::PH_W_HIGH;
        i2cee_pkg::PH_W_HIGH: begin
          phase_next = (bit_inc >= 4'd8) ? i2cee_pkg::PH_W_END_LOW : i2cee_pkg::PH_W_LOW;
        end
        i2cee_pkg::PH_W_END_LOW: phase_next = i2cee_pkg::PH_W_END_REL;
        i2cee_pkg::PH_W_END_REL: phase_next = i2cee_pkg::PH_ACK_HIGH;
        i2cee_pkg::PH_ACK_HIGH:  phase_next = i2cee_pkg::PH_ACK_WAIT;
        i2cee_pkg::PH_ACK_WAIT: begin
          if (ack_done) begin
            if (!mode_is_read) begin
              phase_next = (byte_inc >= WRITE_BYTES) ? i2cee_pkg::PH_SP_A
                                                     : i2cee_pkg::PH_W_LOW;
            end else if (byte_inc == 8'd3) begin
              phase_next = i2cee_pkg::PH_ST_A;
            end else if (byte_inc >= 8'd4) begin
              phase_next = i2cee_pkg::PH_R_LOW;
            end else begin
              phase_next = i2cee_pkg::PH_W_LOW;
            end
          end
        end
        i2cee_pkg::PH_R_LOW:     phase_next = i2cee_pkg::PH_R_REL;
        i2cee_pkg::PH_R_REL:     phase_next = i2cee_pkg::PH_R_HIGH;
        i2cee_pkg::PH_R_HIGH:    phase_next = i2cee_pkg::PH_R_SAMPLE;
        i2cee_pkg::PH_R_SAMPLE: begin
          if (bit_inc >= 4'd8) begin
            phase_next = (byte_inc >= bytes_wanted) ? i2cee_pkg::PH_SP_A
                                                    : i2cee_pkg::PH_MA_LOW;
          end else begin
            phase_next = i2cee_pkg::PH_R_HIGH;
          end
        end
        i2cee_pkg::PH_MA_LOW:    phase_next = i2cee_pkg::PH_MA_SDA;
        i2cee_pkg::PH_MA_SDA:    phase_next = i2cee_pkg::PH_MA_HIGH;
        i2cee_pkg::PH_MA_HIGH:   phase_next = i2cee_pkg::PH_MA_END;
        i2cee_pkg::PH_MA_END:    phase_next = i2cee_pkg::PH_R_LOW;
        i2cee_pkg::PH_SP_A:      phase_next = i2cee_pkg::PH_SP_B;
        i2cee_pkg::PH_SP_B:      phase_next = i2cee_pkg::PH_SP_C;
        i2cee_pkg::PH_SP_C:      phase_next = i2cee_pkg::PH_IDLE;
        default:                 phase_next = i2cee_pkg::PH_IDLE;
      endcase
    end
  end

  // Line levels, counters and read byte per phase
  always_comb begin
    bit_count_next      = bit_count;
    byte_count_next     = byte_count;
    shift_reg_next      = shift_reg;
    ack_wait_count_next = ack_wait_count;
    scl_reg_next        = scl_reg;
    sda_reg_next        = sda_reg;
    rdata               = 8'd0;
    rvalid              = 1'b0;
    rlast               = 1'b0;
    tout                = 1'b0;
    if (!tick) begin
      if (start_cmd) begin
        byte_count_next = 8'd0;
        bit_count_next  = 4'd0;
      end
    end else begin
      unique case (phase)
        i2cee_pkg::PH_ST_A:      sda_reg_next = 1'b1;
        i2cee_pkg::PH_ST_B:      scl_reg_next = 1'b1;
        i2cee_pkg::PH_ST_C: begin
          sda_reg_next   = 1'b0;
          shift_reg_next = tx_byte;
          bit_count_next = 4'd0;
        end
        i2cee_pkg::PH_W_LOW:     scl_reg_next = 1'b0;
        i2cee_pkg::PH_W_DATA: begin
          sda_reg_next   = shift_reg[7];
          shift_reg_next = {shift_reg[6:0], 1'b0};
        end
        i2cee_pkg::PH_W_HIGH: begin
          scl_reg_next   = 1'b1;
          bit_count_next = bit_inc;
        end
        i2cee_pkg::PH_W_END_LOW: scl_reg_next = 1'b0;
        i2cee_pkg::PH_W_END_REL: sda_reg_next = 1'b1;
        i2cee_pkg::PH_ACK_HIGH: begin
          scl_reg_next        = 1'b1;
          ack_wait_count_next = 8'd0;
        end
        i2cee_pkg::PH_ACK_WAIT: begin
          if (q_item.sda) begin
            ack_wait_count_next = wait_inc;
            tout                = ack_done;
          end
          if (ack_done) begin
            scl_reg_next    = 1'b0;
            byte_count_next = byte_inc;
            if (mode_is_read && byte_inc >= 8'd4) begin
              byte_count_next = 8'd0;
              bit_count_next  = 4'd0;
              shift_reg_next  = 8'd0;
            end else if (!(mode_is_read && byte_inc == 8'd3) &&
                         !(!mode_is_read && byte_inc >= WRITE_BYTES)) begin
              shift_reg_next = tx_byte;
              bit_count_next = 4'd0;
            end
          end
        end
        i2cee_pkg::PH_R_LOW:     scl_reg_next = 1'b0;
        i2cee_pkg::PH_R_REL: begin
          sda_reg_next   = 1'b1;
          bit_count_next = 4'd0;
        end
        i2cee_pkg::PH_R_HIGH:    scl_reg_next = 1'b1;
        i2cee_pkg::PH_R_SAMPLE: begin
          scl_reg_next = 1'b0;
          if (bit_inc >= 4'd8) begin
            rdata           = {shift_reg[6:0], q_item.sda};
            rvalid          = 1'b1;
            rlast           = (byte_inc >= bytes_wanted);
            byte_count_next = byte_inc;
            shift_reg_next  = 8'd0;
            bit_count_next  = 4'd0;
          end else begin
            shift_reg_next = {shift_reg[6:0], q_item.sda};
            bit_count_next = bit_inc;
          end
        end
        i2cee_pkg::PH_MA_LOW:    scl_reg_next = 1'b0;
        i2cee_pkg::PH_MA_SDA:    sda_reg_next = 1'b0;
        i2cee_pkg::PH_MA_HIGH:   scl_reg_next = 1'b1;
        i2cee_pkg::PH_MA_END:    scl_reg_next = 1'b0;
        i2cee_pkg::PH_SP_A:      sda_reg_next = 1'b0;
        i2cee_pkg::PH_SP_B:      scl_reg_next = 1'b1;
        i2cee_pkg::PH_SP_C:      sda_reg_next = 1'b1;
        default: begin
        end
      endcase
    end
  end

  // Assemble the result beat
  always_comb begin
    res_next.scl           = scl_reg_next;
    res_next.sda           = sda_reg_next;
    res_next.read_data     = rdata;
    res_next.read_valid    = rvalid;
    res_next.read_last     = rlast;
    res_next.busy          = (phase_next != i2cee_pkg::PH_IDLE);
    res_next.ack_timed_out = tout;
  end

  // Sequencer and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= i2cee_pkg::PH_IDLE;
      bit_count      <= 4'd0;
      byte_count     <= 8'd0;
      shift_reg      <= 8'd0;
      ack_wait_count <= 8'd0;
      target_address <= '0;
      bytes_wanted   <= 8'd0;
      mode_is_read   <= 1'b0;
      scl_reg        <= 1'b1;
      sda_reg        <= 1'b1;
      device_address <= i2cee_pkg::DEVICE_ADDRESS_RESET;
      ack_timeout    <= i2cee_pkg::ACK_TIMEOUT_RESET;
      out_valid      <= 1'b0;
    end else begin
      if (cfg.we) begin
        unique case (cfg.index)
          i2cee_pkg::CFG_DEVICE_ADDRESS: device_address <= cfg.data[6:0];
          i2cee_pkg::CFG_ACK_TIMEOUT:    ack_timeout    <= cfg.data;
          default: begin
          end
        endcase
      end
      if (q_pop) begin
        phase          <= phase_next;
        bit_count      <= bit_count_next;
        byte_count     <= byte_count_next;
        shift_reg      <= shift_reg_next;
        ack_wait_count <= ack_wait_count_next;
        scl_reg        <= scl_reg_next;
        sda_reg        <= sda_reg_next;
        if (start_cmd) begin
          target_address <= q_item.addr;
          bytes_wanted   <= q_item.rlen;
          mode_is_read   <= (q_item.kind == i2cee_pkg::OP_READ);
        end
      end
      if (q_pop) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold the result beat and the page buffer
  always_ff @(posedge clk) begin
    if (q_pop) begin
      res <= res_next;
      if (load_cmd) begin
        page_buffer[q_item.bidx] <= q_item.wbyte;
      end
    end
  end

  a_bit_count_range: assert property (@(posedge clk) disable iff (rst)
    bit_count <= 4'd8)
    else $error("bit counter beyond one byte");

  a_write_byte_range: assert property (@(posedge clk) disable iff (rst)
    !mode_is_read |-> byte_count <= WRITE_BYTES)
    else $error("write byte counter beyond page");

  a_ack_leaves_wait: assert property (@(posedge clk) disable iff (rst)
    (q_pop && tick && phase == i2cee_pkg::PH_ACK_WAIT && ack_done)
      |=> phase != i2cee_pkg::PH_ACK_WAIT)
    else $error("acknowledge wait not left after ack or timeout");

  a_busy_matches_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> res.busy == (phase != i2cee_pkg::PH_IDLE))
    else $error("busy flag disagrees with sequencer phase");

  a_last_needs_valid: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res.read_last) |-> res.read_valid)
    else $error("read_last without read_valid");

endmodule

@@ rtl/i2c_eeprom_master.sv @@
// Each input beat passes through the queue and then the result register before it is offered.
// Throughput: one beat per cycle unless stalled; the 4-entry queue and the result register
// let either side stall while the other moves; the sequencer moves at most one phase per beat.
// Reset: synchronous, active high; sequencer idle, lines released high, registers at defaults.
// The page buffer is not cleared by reset and holds whatever was last loaded.
// Top level of the I2C serial-memory master; depends on i2cee_pkg, i2cee_front, i2cee_back.
module i2c_eeprom_master (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [0:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [12:0] mem_address,
  input  logic [4:0]  buffer_index,
  input  logic [7:0]  write_byte,
  input  logic [7:0]  read_length,
  input  logic        sda_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        scl_level,
  output logic        sda_level,
  output logic [7:0]  read_data,
  output logic        read_valid,
  output logic        read_last,
  output logic        busy_res,
  output logic        ack_timed_out
);

  i2cee_pkg::cfg_wr_t  cfg;
  i2cee_pkg::item_t    q_item;
  i2cee_pkg::result_t  res;
  logic                q_valid;
  logic                q_pop;

  // Bundle the configuration write
  always_comb begin
    cfg.we    = cfg_write;
    cfg.index = i2cee_pkg::cfg_idx_t'(cfg_index);
    cfg.data  = cfg_data;
  end

  i2cee_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (opcode),
    .mem_address  (mem_address),
    .buffer_index (buffer_index),
    .write_byte   (write_byte),
    .read_length  (read_length),
    .sda_in       (sda_in),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop)
  );

  i2cee_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  // Unpack the result beat
  assign scl_level     = res.scl;
  assign sda_level     = res.sda;
  assign read_data     = res.read_data;
  assign read_valid    = res.read_valid;
  assign read_last     = res.read_last;
  assign busy_res      = res.busy;
  assign ack_timed_out = res.ack_timed_out;

endmodule

@@ verif/i2c_eeprom_master_checker.sv @@
`timescale 1ns / 1ps
// Result checker for the I2C serial-memory master: tracks the bus sequencer
// beat by beat from the input channel and compares each result beat.
// Depends on i2cee_pkg for the opcode, phase, register index and result types.
module i2c_eeprom_master_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [0:0]          cfg_index,
  input  logic [7:0]          cfg_data,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [1:0]          opcode,
  input  logic [12:0]         mem_address,
  input  logic [4:0]          buffer_index,
  input  logic [7:0]          write_byte,
  input  logic [7:0]          read_length,
  input  logic                sda_in,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic                scl_level,
  input  logic                sda_level,
  input  logic [7:0]          read_data,
  input  logic                read_valid,
  input  logic                read_last,
  input  logic                busy_res,
  input  logic                ack_timed_out,
  output int                  mismatch_count,
  output int                  pending,
  output i2cee_pkg::phase_t   bus_phase
);
  import i2cee_pkg::*;

  // Mirror of the sequencer state and its two registers
  logic [7:0] page_copy [PAGE_BYTES];
  phase_t     ph;
  logic [3:0] bits_done;
  logic [7:0] bytes_done;
  logic [7:0] shifter;
  logic [7:0] high_samples;
  addr_t      mem_target;
  logic [7:0] read_total;
  logic       reading;
  logic       scl_q;
  logic       sda_q;
  logic [6:0] dev_addr;
  logic [7:0] ack_limit;

  // Line states and read bytes still owed by the block, oldest first
  result_t    bus_results_due [$];

  // Byte sent in a given slot of the outgoing sequence
  function automatic logic [7:0] outgoing_byte(logic [7:0] slot);
    logic [7:0] dev;
    dev = {dev_addr, 1'b0};
    if (slot == 8'd0) return dev;
    if (slot == 8'd1) return 8'(mem_target >> 8);
    if (slot == 8'd2) return mem_target[7:0];
    if (reading) return dev | 8'd1;
    if (slot - 8'd3 < PAGE_BYTES) return page_copy[slot - 8'd3];
    return 8'd0;
  endfunction

  function automatic void load_outgoing();
    shifter   = outgoing_byte(bytes_done);
    bits_done = '0;
    ph        = PH_W_LOW;
  endfunction

  // Move on once an acknowledge arrived or its wait ran out
  function automatic void finish_ack();
    bytes_done = bytes_done + 8'd1;
    if (!reading) begin
      if (bytes_done >= 8'(3 + PAGE_BYTES)) ph = PH_SP_A;
      else load_outgoing();
    end else if (bytes_done == 8'd3) begin
      ph = PH_ST_A;
    end else if (bytes_done >= 8'd4) begin
      bytes_done = '0;
      bits_done  = '0;
      shifter    = '0;
      ph         = PH_R_LOW;
    end else begin
      load_outgoing();
    end
  endfunction

  // Apply one input beat to the mirror and return the line state it leaves
  function automatic result_t advance_bus_phase(opcode_t op, addr_t addr, page_idx_t slot,
                                                logic [7:0] data, logic [7:0] len, logic sda);
    result_t r;
    r = '0;
    if (op != OP_TICK) begin
      // commands only land on an idle sequencer
      if (ph == PH_IDLE) begin
        if (op == OP_LOAD) begin
          page_copy[slot] = data;
        end else begin
          mem_target = addr;
          reading    = (op == OP_READ);
          read_total = len;
          bytes_done = '0;
          bits_done  = '0;
          ph         = PH_ST_A;
        end
      end
    end else begin
      case (ph)
        PH_IDLE: ;
        PH_ST_A: begin
          sda_q = 1'b1;
          ph    = PH_ST_B;
        end
        PH_ST_B: begin
          scl_q = 1'b1;
          ph    = PH_ST_C;
        end
        PH_ST_C: begin
          sda_q = 1'b0;
          load_outgoing();
        end
        PH_W_LOW: begin
          scl_q = 1'b0;
          ph    = PH_W_DATA;
        end
        PH_W_DATA: begin
          sda_q   = shifter[7];
          shifter = {shifter[6:0], 1'b0};
          ph      = PH_W_HIGH;
        end
        PH_W_HIGH: begin
          scl_q     = 1'b1;
          bits_done = bits_done + 4'd1;
          ph        = (bits_done >= 4'd8) ? PH_W_END_LOW : PH_W_LOW;
        end
        PH_W_END_LOW: begin
          scl_q = 1'b0;
          ph    = PH_W_END_REL;
        end
        PH_W_END_REL: begin
          sda_q = 1'b1;
          ph    = PH_ACK_HIGH;
        end
        PH_ACK_HIGH: begin
          scl_q        = 1'b1;
          high_samples = '0;
          ph           = PH_ACK_WAIT;
        end
        PH_ACK_WAIT: begin
          // a low line acknowledges; each high sample counts toward the timeout
          if (!sda) begin
            scl_q = 1'b0;
            finish_ack();
          end else begin
            high_samples = high_samples + 8'd1;
            if (high_samples >= ack_limit) begin
              scl_q           = 1'b0;
              r.ack_timed_out = 1'b1;
              finish_ack();
            end
          end
        end
        PH_R_LOW: begin
          scl_q = 1'b0;
          ph    = PH_R_REL;
        end
        PH_R_REL: begin
          sda_q     = 1'b1;
          bits_done = '0;
          ph        = PH_R_HIGH;
        end
        PH_R_HIGH: begin
          scl_q = 1'b1;
          ph    = PH_R_SAMPLE;
        end
        PH_R_SAMPLE: begin
          shifter   = {shifter[6:0], sda};
          scl_q     = 1'b0;
          bits_done = bits_done + 4'd1;
          if (bits_done >= 4'd8) begin
            r.read_data  = shifter;
            r.read_valid = 1'b1;
            bytes_done   = bytes_done + 8'd1;
            // a zero length ends after the first byte, same as one
            if (bytes_done >= read_total) begin
              r.read_last = 1'b1;
              ph          = PH_SP_A;
            end else begin
              ph = PH_MA_LOW;
            end
            shifter   = '0;
            bits_done = '0;
          end else begin
            ph = PH_R_HIGH;
          end
        end
        PH_MA_LOW: begin
          scl_q = 1'b0;
          ph    = PH_MA_SDA;
        end
        PH_MA_SDA: begin
          sda_q = 1'b0;
          ph    = PH_MA_HIGH;
        end
        PH_MA_HIGH: begin
          scl_q = 1'b1;
          ph    = PH_MA_END;
        end
        PH_MA_END: begin
          scl_q = 1'b0;
          ph    = PH_R_LOW;
        end
        PH_SP_A: begin
          sda_q = 1'b0;
          ph    = PH_SP_B;
        end
        PH_SP_B: begin
          scl_q = 1'b1;
          ph    = PH_SP_C;
        end
        PH_SP_C: begin
          sda_q = 1'b1;
          ph    = PH_IDLE;
        end
        default: ph = PH_IDLE;
      endcase
    end
    r.scl  = scl_q;
    r.sda  = sda_q;
    r.busy = (ph != PH_IDLE);
    return r;
  endfunction

  // Watch both channels and the register port at every rising edge
  always @(posedge clk) begin : watch
    result_t want;
    result_t got;
    if (rst) begin
      ph           = PH_IDLE;
      bits_done    = '0;
      bytes_done   = '0;
      shifter      = '0;
      high_samples = '0;
      mem_target   = '0;
      read_total   = '0;
      reading      = 1'b0;
      scl_q        = 1'b1;
      sda_q        = 1'b1;
      dev_addr     = DEVICE_ADDRESS_RESET;
      ack_limit    = ACK_TIMEOUT_RESET;
      bus_results_due.delete();
    end else begin
      if (cfg_write) begin
        if (cfg_idx_t'(cfg_index) == CFG_DEVICE_ADDRESS) dev_addr = cfg_data[6:0];
        else ack_limit = cfg_data;
      end
      // predict before comparing: a beat taken now never leaves in the same cycle
      if (in_valid && in_ready) begin
        bus_results_due.push_back(advance_bus_phase(opcode_t'(opcode), mem_address,
                                                    buffer_index, write_byte, read_length,
                                                    sda_in));
      end
      if (out_valid && out_ready) begin
        got = '{scl: scl_level, sda: sda_level, read_data: read_data, read_valid: read_valid,
                read_last: read_last, busy: busy_res, ack_timed_out: ack_timed_out};
        if (bus_results_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: result beat with nothing outstanding: %p", $realtime, got);
        end else begin
          want = bus_results_due.pop_front();
          if (got.scl !== want.scl || got.sda !== want.sda ||
              got.read_data !== want.read_data || got.read_valid !== want.read_valid ||
              got.read_last !== want.read_last || got.busy !== want.busy ||
              got.ack_timed_out !== want.ack_timed_out) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("%0t: result mismatch, expected %p", $realtime, want);
              $display("%0t:                      got %p", $realtime, got);
            end
          end
        end
      end
    end
    pending   = bus_results_due.size();
    bus_phase = ph;
  end

endmodule

@@ verif/i2c_eeprom_master_tb.sv @@
`timescale 1ns / 1ps
// Testbench top for the I2C serial-memory master: drives commands and bus ticks,
// paces both channels and gives the verdict.
// Depends on i2cee_pkg, i2c_eeprom_master and i2c_eeprom_master_checker.
module i2c_eeprom_master_tb;
  import i2cee_pkg::*;

  // How the memory side answers acknowledge windows
  typedef enum int {
    ACK_CLEAN,
    ACK_NOISY,
    ACK_ABSENT
  } ack_style_t;

  // Pace of the result sink
  typedef enum int {
    SINK_OPEN,
    SINK_RANDOM,
    SINK_PERIODIC
  } sink_pace_t;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        cfg_write    = 1'b0;
  logic [0:0]  cfg_index    = '0;
  logic [7:0]  cfg_data     = '0;
  logic        in_valid     = 1'b0;
  logic        in_ready;
  logic [1:0]  opcode       = '0;
  logic [12:0] mem_address  = '0;
  logic [4:0]  buffer_index = '0;
  logic [7:0]  write_byte   = '0;
  logic [7:0]  read_length  = '0;
  logic        sda_in       = 1'b1;
  logic        out_valid;
  logic        out_ready    = 1'b0;
  logic        scl_level;
  logic        sda_level;
  logic [7:0]  read_data;
  logic        read_valid;
  logic        read_last;
  logic        busy_res;
  logic        ack_timed_out;

  int          mismatch_count;
  int          pending;
  phase_t      bus_phase;

  int          beats_sent    = 0;
  int          burst_left    = 0;
  int          pages_written = 0;
  int          reads_run     = 0;
  int          reg_writes    = 0;
  logic        valid_up      = 1'b0;
  logic        hold_req      = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  i2c_eeprom_master i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .opcode        (opcode),
    .mem_address   (mem_address),
    .buffer_index  (buffer_index),
    .write_byte    (write_byte),
    .read_length   (read_length),
    .sda_in        (sda_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .scl_level     (scl_level),
    .sda_level     (sda_level),
    .read_data     (read_data),
    .read_valid    (read_valid),
    .read_last     (read_last),
    .busy_res      (busy_res),
    .ack_timed_out (ack_timed_out)
  );

  i2c_eeprom_master_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .opcode         (opcode),
    .mem_address    (mem_address),
    .buffer_index   (buffer_index),
    .write_byte     (write_byte),
    .read_length    (read_length),
    .sda_in         (sda_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .scl_level      (scl_level),
    .sda_level      (sda_level),
    .read_data      (read_data),
    .read_valid     (read_valid),
    .read_last      (read_last),
    .busy_res       (busy_res),
    .ack_timed_out  (ack_timed_out),
    .mismatch_count (mismatch_count),
    .pending        (pending),
    .bus_phase      (bus_phase)
  );

  // Hard stop in case the block hangs
  initial begin
    #10_000_000;
    $display("i2c_eeprom_master_tb: errors");
    $finish;
  end

  // Result sink: a long hold on request, otherwise a pace that changes now and then
  initial begin : sink
    sink_pace_t pace;
    int         pace_left;
    int         held;
    int         slot;
    int         stall_len;
    pace      = SINK_OPEN;
    pace_left = 0;
    held      = 0;
    slot      = 0;
    stall_len = 1;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        held++;
        if (held >= 150) begin
          hold_req = 1'b0;
          held     = 0;
        end
      end else begin
        if (pace_left == 0) begin
          pace      = sink_pace_t'($urandom_range(0, 2));
          pace_left = $urandom_range(30, 300);
          stall_len = $urandom_range(1, 5);
        end
        pace_left--;
        slot = (slot + 1) % 6;
        case (pace)
          SINK_OPEN:   out_ready <= 1'b1;
          SINK_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
          default:     out_ready <= (slot >= stall_len);
        endcase
      end
    end
  end

  // Drop valid if it is up; called at a falling edge
  task automatic drop_valid();
    if (valid_up) begin
      in_valid <= 1'b0;
      valid_up = 1'b0;
    end
  endtask

  // Offer one beat in a burst; starts and returns at a falling edge
  task automatic send_beat(opcode_t op, logic [12:0] addr, logic [4:0] slot,
                           logic [7:0] data, logic [7:0] len, logic sda);
    if (burst_left == 0) begin
      drop_valid();
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid     <= 1'b1;
    valid_up     = 1'b1;
    opcode       <= op;
    mem_address  <= addr;
    buffer_index <= slot;
    write_byte   <= data;
    read_length  <= len;
    sda_in       <= sda;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    beats_sent++;
  endtask

  // One bus phase; the data line answers acknowledge windows per style
  task automatic send_tick(ack_style_t style);
    logic sda;
    if (bus_phase == PH_ACK_WAIT) begin
      case (style)
        ACK_CLEAN: sda = ($urandom_range(0, 9) == 0);
        ACK_NOISY: sda = 1'($urandom);
        default:   sda = 1'b1;
      endcase
    end else begin
      sda = 1'($urandom);
    end
    send_beat(OP_TICK, 13'($urandom), 5'($urandom), 8'($urandom), 8'($urandom), sda);
  endtask

  // Tick until the sequencer is idle, now and then slipping in a command it must ignore
  task automatic finish_transfer(ack_style_t style);
    while (bus_phase != PH_IDLE) begin
      if ($urandom_range(0, 19) == 0)
        send_beat(opcode_t'($urandom_range(1, 3)), 13'($urandom), 5'($urandom),
                  8'($urandom), 8'($urandom), 1'($urandom));
      else
        send_tick(style);
    end
  endtask

  task automatic load_slot(logic [4:0] slot, logic [7:0] data);
    send_beat(OP_LOAD, 13'($urandom), slot, data, 8'($urandom), 1'($urandom));
  endtask

  task automatic write_page(logic [12:0] addr, ack_style_t style);
    send_beat(OP_WRITE, addr, 5'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
    finish_transfer(style);
    pages_written++;
  endtask

  task automatic page_read(logic [12:0] addr, logic [7:0] len, ack_style_t style);
    send_beat(OP_READ, addr, 5'($urandom), 8'($urandom), len, 1'($urandom));
    finish_transfer(style);
    reads_run++;
  endtask

  // Hold input until every result beat is back, then let the pipe settle
  task automatic wait_results();
    drop_valid();
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [7:0] value);
    wait_results();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    reg_writes++;
  endtask

  initial begin : stimulus
    int         i;
    int         n;
    int         start_beats;
    int         pick;
    logic       short_wait;
    ack_style_t style;

    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // idle bus ignores ticks
    send_beat(OP_TICK, '1, '1, '1, '1, 1'b1);
    send_beat(OP_TICK, '0, '0, '0, '0, 1'b0);

    // fill the whole page buffer, edge values at both ends
    for (i = 0; i < PAGE_BYTES; i++)
      load_slot(5'(i), (i == 0) ? 8'h00 : (i == PAGE_BYTES - 1) ? 8'hFF : 8'($urandom));

    // page write at the top address while the sink holds off and the queue backs up
    hold_req = 1'b1;
    write_page(13'h1FFF, ACK_CLEAN);

    // reads: one byte, zero length, longest run
    page_read(13'h0000, 8'd1, ACK_CLEAN);
    page_read(13'h0A5A, 8'd0, ACK_CLEAN);
    page_read(13'h1555, 8'd255, ACK_CLEAN);

    // device address extremes; the top data bit is dropped
    write_reg(CFG_DEVICE_ADDRESS, 8'd0);
    page_read(13'($urandom), 8'd2, ACK_CLEAN);
    write_reg(CFG_DEVICE_ADDRESS, 8'hFF);
    load_slot(5'd31, 8'hA5);
    write_page(13'h0000, ACK_NOISY);

    // acknowledge timeouts: shortest, zero, longest
    write_reg(CFG_ACK_TIMEOUT, 8'd1);
    page_read(13'($urandom), 8'd3, ACK_ABSENT);
    write_reg(CFG_ACK_TIMEOUT, 8'd0);
    page_read(13'($urandom), 8'd1, ACK_NOISY);
    write_reg(CFG_ACK_TIMEOUT, 8'd255);
    page_read(13'($urandom), 8'd2, ACK_ABSENT);
    short_wait = 1'b0;

    // random transfers with random content
    start_beats = beats_sent;
    while (beats_sent - start_beats < 1000) begin
      if ($urandom_range(0, 5) == 0) begin
        write_reg(CFG_DEVICE_ADDRESS, 8'($urandom));
        case ($urandom_range(0, 3))
          0: begin
            write_reg(CFG_ACK_TIMEOUT, 8'($urandom_range(0, 3)));
            short_wait = 1'b1;
          end
          1: begin
            write_reg(CFG_ACK_TIMEOUT, 8'($urandom));
            short_wait = 1'b0;
          end
          default: begin
            write_reg(CFG_ACK_TIMEOUT, ACK_TIMEOUT_RESET);
            short_wait = 1'b0;
          end
        endcase
      end

      // mostly clean acknowledges; silent memory only when the wait is short
      pick = $urandom_range(0, 9);
      if (pick < 7) style = ACK_CLEAN;
      else if (pick == 9 && short_wait) style = ACK_ABSENT;
      else style = ACK_NOISY;

      pick = $urandom_range(0, 19);
      if (pick < 9) begin
        page_read(13'($urandom),
                  ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 40))
                                              : 8'($urandom_range(1, 4)),
                  style);
      end else if (pick < 12) begin
        write_page(13'($urandom), style);
      end else if (pick < 17) begin
        repeat ($urandom_range(1, 8)) load_slot(5'($urandom), 8'($urandom));
      end else if (pick < 19) begin
        // ticks on an idle bus do not count toward the run
        n = $urandom_range(1, 4);
        repeat (n) send_beat(OP_TICK, 13'($urandom), 5'($urandom), 8'($urandom),
                             8'($urandom), 1'($urandom));
        start_beats += n;
      end else begin
        // pause for all results, or make the sink hold off again
        if ($urandom_range(0, 1) == 0) wait_results();
        else hold_req = 1'b1;
      end
    end

    wait_results();
    repeat (10) @(negedge clk);
    $display("Run covered %0d beats: %0d page writes, %0d reads, %0d register writes.",
             beats_sent, pages_written, reads_run, reg_writes);
    if (mismatch_count == 0 && pending == 0)
      $display("i2c_eeprom_master_tb: clean");
    else
      $display("i2c_eeprom_master_tb: errors");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/i2cee_pkg.sv
rtl/i2cee_front.sv
rtl/i2cee_back.sv
rtl/i2c_eeprom_master.sv
verif/i2c_eeprom_master_checker.sv
verif/i2c_eeprom_master_tb.sv
